@@ hdl/tsra_pkg.sv @@
// Types, codes and helpers shared by the tagged stack-relative ALU files.
package tsra_pkg;

   // operand tags
   localparam logic [1:0] TAG_INV = 2'd0;
   localparam logic [1:0] TAG_ABS = 2'd1;
   localparam logic [1:0] TAG_REL = 2'd2;

   // operation codes
   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_NEG = 4'd2;
   localparam logic [3:0] OP_NOT = 4'd3;
   localparam logic [3:0] OP_MUL = 4'd4;
   localparam logic [3:0] OP_DIV = 4'd5;
   localparam logic [3:0] OP_MOD = 4'd6;
   localparam logic [3:0] OP_SHL = 4'd7;
   localparam logic [3:0] OP_SHR = 4'd8;
   localparam logic [3:0] OP_EQ  = 4'd9;
   localparam logic [3:0] OP_GT  = 4'd10;

   // which late result the output stage picks
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_MUL  = 2'd1;
   localparam logic [1:0] PEND_DIV  = 2'd2;
   localparam logic [1:0] PEND_MOD  = 2'd3;

   localparam int unsigned DIV_STEPS = 32;

   typedef struct packed {
      logic [3:0]         kind;
      logic signed [31:0] a_value;
      logic [1:0]         a_tag;
      logic               a_sign;
      logic signed [31:0] b_value;
      logic [1:0]         b_tag;
      logic               b_sign;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_value;
      logic [1:0]         r_tag;
      logic               r_sign;
      logic               r_flag;
   } rsp_type;

   // state carried down the pipeline with each request
   typedef struct packed {
      rsp_type     res;
      logic [1:0]  pend;
      logic [31:0] prod;
      logic [31:0] quo;
      logic [31:0] rem;
      logic [31:0] dvs;
      logic        neg_q;
      logic        neg_r;
   } pipe_type;

   // build a tagged value, clearing fields the tag does not use
   function automatic rsp_type mk(input logic [31:0] v, input logic [1:0] t, input logic s);
      rsp_type r;
      r.r_value = (t == TAG_INV) ? 32'sd0 : v;
      r.r_tag   = t;
      r.r_sign  = (t == TAG_REL) ? s : 1'b0;
      r.r_flag  = 1'b0;
      return r;
   endfunction

endpackage

@@ hdl/tsra_if.sv @@
// Valid/ready channels carrying requests and results.
interface tsra_req_if;
   import tsra_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tsra_rsp_if;
   import tsra_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/tsra_decode.sv @@
// Operand decode and every early-result operation, with the low product.
module tsra_decode (
   input  tsra_pkg::req_type  req_data,
   output tsra_pkg::pipe_type dec
);
   import tsra_pkg::*;

   logic [1:0]  a_t, b_t;
   logic [31:0] a_v, b_v, nv;
   logic        a_s, b_s, bs, sub;
   logic        ak0, ak1, akm, bk0, bk1, bkm, both_abs;
   rsp_type     a_r, b_r, a_n, b_n, abs0;

   // normalise operands: tag three reads as invalid
   always_comb begin
      a_t = (req_data.a_tag == 2'd3) ? TAG_INV : req_data.a_tag;
      b_t = (req_data.b_tag == 2'd3) ? TAG_INV : req_data.b_tag;
      a_v = (a_t == TAG_INV) ? 32'd0 : req_data.a_value;
      b_v = (b_t == TAG_INV) ? 32'd0 : req_data.b_value;
      a_s = (a_t == TAG_REL) ? req_data.a_sign : 1'b0;
      b_s = (b_t == TAG_REL) ? req_data.b_sign : 1'b0;
   end

   assign ak0 = (a_t == TAG_ABS) && (a_v == 32'd0);
   assign ak1 = (a_t == TAG_ABS) && (a_v == 32'd1);
   assign akm = (a_t == TAG_ABS) && (a_v == 32'hFFFF_FFFF);
   assign bk0 = (b_t == TAG_ABS) && (b_v == 32'd0);
   assign bk1 = (b_t == TAG_ABS) && (b_v == 32'd1);
   assign bkm = (b_t == TAG_ABS) && (b_v == 32'hFFFF_FFFF);
   assign both_abs = (a_t == TAG_ABS) && (b_t == TAG_ABS);

   assign a_r  = mk(a_v, a_t, a_s);
   assign b_r  = mk(b_v, b_t, b_s);
   assign a_n  = mk(32'd0 - a_v, a_t, ~a_s);
   assign b_n  = mk(32'd0 - b_v, b_t, ~b_s);
   assign abs0 = mk(32'd0, TAG_ABS, 1'b0);

   assign sub = (req_data.kind == OP_SUB);
   assign nv  = sub ? (a_v - b_v) : (a_v + b_v);
   assign bs  = sub ? ~b_s : b_s;

   // select the early result, or mark a late one
   always_comb begin
      dec.res  = mk(32'd0, TAG_INV, 1'b0);
      dec.pend = PEND_NONE;
      case (req_data.kind)
         OP_ADD, OP_SUB: begin
            if (a_t == TAG_ABS && b_t == TAG_ABS) dec.res = mk(nv, TAG_ABS, 1'b0);
            else if (a_t == TAG_ABS && b_t == TAG_REL) dec.res = mk(nv, TAG_REL, bs);
            else if (a_t == TAG_REL && b_t == TAG_ABS) dec.res = mk(nv, TAG_REL, a_s);
            else if (a_t == TAG_REL && b_t == TAG_REL && a_s != bs)
               dec.res = mk(nv, TAG_ABS, 1'b0);
         end
         OP_NEG: dec.res = a_n;
         OP_NOT: begin
            if (a_t == TAG_ABS) dec.res = mk(~a_v, TAG_ABS, 1'b0);
         end
         OP_MUL: begin
            if (ak0 || bk0) dec.res = abs0;
            else if (bk1) dec.res = a_r;
            else if (bkm) dec.res = a_n;
            else if (ak1) dec.res = b_r;
            else if (akm) dec.res = b_n;
            else if (both_abs) dec.pend = PEND_MUL;
         end
         OP_DIV: begin
            if (bk0) dec.res = mk(32'd0, TAG_INV, 1'b0);
            else if (ak0) dec.res = abs0;
            else if (bk1) dec.res = a_r;
            else if (bkm) dec.res = a_n;
            else if (both_abs) dec.pend = PEND_DIV;
         end
         OP_MOD: begin
            if (b_t != TAG_ABS || b_v == 32'd0) dec.res = mk(32'd0, TAG_INV, 1'b0);
            else if (ak0 || bk1 || bkm) dec.res = abs0;
            else if (a_t == TAG_ABS) dec.pend = PEND_MOD;
         end
         OP_SHL, OP_SHR: begin
            if (bk0) dec.res = a_r;
            else if (both_abs && b_v <= 32'd31) begin
               if (sub || req_data.kind == OP_SHL) dec.res = mk(a_v << b_v[4:0], TAG_ABS, 1'b0);
               else dec.res = mk($signed(a_v) >>> b_v[4:0], TAG_ABS, 1'b0);
            end
         end
         OP_EQ: begin
            dec.res.r_flag = (a_t == b_t) && (a_v == b_v) && (a_s == b_s);
         end
         OP_GT: begin
            if (a_t != b_t) dec.res.r_flag = (a_t > b_t);
            else if (a_t == TAG_INV) dec.res.r_flag = 1'b0;
            else if (a_t == TAG_REL && a_s != b_s) dec.res.r_flag = a_s;
            else dec.res.r_flag = ($signed(a_v) > $signed(b_v));
         end
         default: dec.res = mk(32'd0, TAG_INV, 1'b0);
      endcase
   end

   // operands for the late units: magnitudes for the divider
   assign dec.prod  = a_v * b_v;
   assign dec.quo   = a_v[31] ? (32'd0 - a_v) : a_v;
   assign dec.dvs   = b_v[31] ? (32'd0 - b_v) : b_v;
   assign dec.rem   = 32'd0;
   assign dec.neg_q = a_v[31] ^ b_v[31];
   assign dec.neg_r = a_v[31];

endmodule

@@ hdl/tsra_div_step.sv @@
// One restoring division step: one quotient bit per pipeline stage.
module tsra_div_step (
   input  tsra_pkg::pipe_type cur,
   output tsra_pkg::pipe_type nxt
);
   import tsra_pkg::*;

   logic [32:0] r2, diff;
   logic        take;

   assign r2   = {cur.rem, cur.quo[31]};
   assign diff = r2 - {1'b0, cur.dvs};
   assign take = ~diff[32];

   // shift in the next dividend bit and try the subtract
   always_comb begin
      nxt     = cur;
      nxt.rem = take ? diff[31:0] : r2[31:0];
      nxt.quo = {cur.quo[30:0], take};
   end

endmodule

@@ hdl/tagged_stack_relative_alu_core.sv @@
// Top level: pipelined tagged stack-relative ALU.
//
//  channel   direction  handshake          carries
//  req_ch    in         valid/ready        kind, operands a and b with tags
//  rsp_ch    out        valid/ready        r_value, r_tag, r_sign, r_flag
//
// One request enters per cycle unless the output stalls; each result
// passes the decode register, the 32 one-bit division stages and rsp_ff.
// Synchronous reset clears the valid bits only.
// The pipeline advances as one: it holds while a result waits unaccepted
// in the output register, and takes a request whenever it advances.
module tagged_stack_relative_alu_core (
   input logic     clock,
   input logic     reset,
   tsra_req_if.sink   req_ch,
   tsra_rsp_if.source rsp_ch
);
   import tsra_pkg::*;

   pipe_type st_ff  [0:DIV_STEPS];
   pipe_type st_in  [0:DIV_STEPS];
   logic     vld_ff [0:DIV_STEPS];
   rsp_type  rsp_ff, rsp_in;
   logic     rsp_vld_ff;
   logic     adv;

   assign adv          = ~rsp_vld_ff | rsp_ch.ready;
   assign req_ch.ready = adv;
   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.data  = rsp_ff;

   // decode and early results
   tsra_decode u_decode (
      .req_data (req_ch.data),
      .dec      (st_in[0])
   );

   // division stages
   for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
      tsra_div_step u_step (
         .cur (st_ff[i-1]),
         .nxt (st_in[i])
      );
   end

   // pick the late result
   always_comb begin
      case (st_ff[DIV_STEPS].pend)
         PEND_MUL: rsp_in = mk(st_ff[DIV_STEPS].prod, TAG_ABS, 1'b0);
         PEND_DIV: rsp_in = mk(st_ff[DIV_STEPS].neg_q ? (32'd0 - st_ff[DIV_STEPS].quo)
                                                       : st_ff[DIV_STEPS].quo, TAG_ABS, 1'b0);
         PEND_MOD: rsp_in = mk(st_ff[DIV_STEPS].neg_r ? (32'd0 - st_ff[DIV_STEPS].rem)
                                                       : st_ff[DIV_STEPS].rem, TAG_ABS, 1'b0);
         default:  rsp_in = st_ff[DIV_STEPS].res;
      endcase
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= DIV_STEPS; i++) st_ff[i] <= st_in[i];
         rsp_ff <= rsp_in;
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS; i++) vld_ff[i] <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_ch.valid;
         for (int i = 1; i <= DIV_STEPS; i++) vld_ff[i] <= vld_ff[i-1];
         rsp_vld_ff <= vld_ff[DIV_STEPS];
      end
   end

endmodule

@@ tb/tsra_check.sv @@
// Result checker for the tagged stack-relative ALU: predicts each result and compares it.
`timescale 1ns / 100ps
module tsra_check
   import tsra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int unsigned fail_count,
   output int unsigned results_due
);

   rsp_type results_queue[$];

   // build a tagged value with unused fields cleared
   function automatic rsp_type tagged_value(logic [31:0] v, logic [1:0] t, logic s);
      rsp_type r;
      r.r_value = (t == TAG_INV) ? 32'd0 : v;
      r.r_tag   = t;
      r.r_sign  = (t == TAG_REL) ? s : 1'b0;
      r.r_flag  = 1'b0;
      return r;
   endfunction

   function automatic rsp_type negated(rsp_type x);
      return tagged_value(32'd0 - x.r_value, x.r_tag, ~x.r_sign);
   endfunction

   function automatic logic is_const(rsp_type x, logic [31:0] k);
      return x.r_tag == TAG_ABS && x.r_value == k;
   endfunction

   function automatic rsp_type add_sub(rsp_type a, rsp_type b, logic sub);
      logic [31:0] nv;
      logic        bs;
      nv = sub ? a.r_value - b.r_value : a.r_value + b.r_value;
      bs = sub ? ~b.r_sign : b.r_sign;
      if (a.r_tag == TAG_ABS && b.r_tag == TAG_ABS) return tagged_value(nv, TAG_ABS, 1'b0);
      if (a.r_tag == TAG_ABS && b.r_tag == TAG_REL) return tagged_value(nv, TAG_REL, bs);
      if (a.r_tag == TAG_REL && b.r_tag == TAG_ABS) return tagged_value(nv, TAG_REL, a.r_sign);
      if (a.r_tag == TAG_REL && b.r_tag == TAG_REL && a.r_sign != bs)
         return tagged_value(nv, TAG_ABS, 1'b0);
      return tagged_value(0, TAG_INV, 0);
   endfunction

   // work out the result of one request
   function automatic rsp_type alu_result(req_type q);
      rsp_type a, b, r;
      logic signed [31:0] x, y;
      logic [1:0] ta, tb;
      ta = (q.a_tag > TAG_REL) ? TAG_INV : q.a_tag;
      tb = (q.b_tag > TAG_REL) ? TAG_INV : q.b_tag;
      a = tagged_value(q.a_value, ta, q.a_sign);
      b = tagged_value(q.b_value, tb, q.b_sign);
      x = a.r_value;
      y = b.r_value;
      r = tagged_value(0, TAG_INV, 0);
      case (q.kind)
         OP_ADD: r = add_sub(a, b, 1'b0);
         OP_SUB: r = add_sub(a, b, 1'b1);
         OP_NEG: r = negated(a);
         OP_NOT: if (a.r_tag == TAG_ABS) r = tagged_value(~a.r_value, TAG_ABS, 0);
         OP_MUL: begin
            if (is_const(a, 0) || is_const(b, 0)) r = tagged_value(0, TAG_ABS, 0);
            else if (is_const(b, 1)) r = a;
            else if (is_const(b, '1)) r = negated(a);
            else if (is_const(a, 1)) r = b;
            else if (is_const(a, '1)) r = negated(b);
            else if (a.r_tag == TAG_ABS && b.r_tag == TAG_ABS)
               r = tagged_value(a.r_value * b.r_value, TAG_ABS, 0);
         end
         OP_DIV: begin
            if (is_const(b, 0)) r = tagged_value(0, TAG_INV, 0);
            else if (is_const(a, 0)) r = tagged_value(0, TAG_ABS, 0);
            else if (is_const(b, 1)) r = a;
            else if (is_const(b, '1)) r = negated(a);
            else if (a.r_tag == TAG_ABS && b.r_tag == TAG_ABS)
               r = tagged_value(x / y, TAG_ABS, 0);
         end
         OP_MOD: begin
            if (b.r_tag != TAG_ABS || b.r_value == 0) r = tagged_value(0, TAG_INV, 0);
            else if (is_const(a, 0) || b.r_value == 1 || b.r_value == '1)
               r = tagged_value(0, TAG_ABS, 0);
            else if (a.r_tag == TAG_ABS) r = tagged_value(x % y, TAG_ABS, 0);
         end
         OP_SHL, OP_SHR: begin
            if (is_const(b, 0)) r = a;
            else if (a.r_tag == TAG_ABS && b.r_tag == TAG_ABS
                     && $unsigned(b.r_value) < 32'd32)
               r = tagged_value((q.kind == OP_SHL) ? a.r_value << b.r_value[4:0]
                                : x >>> b.r_value[4:0], TAG_ABS, 0);
         end
         OP_EQ: r.r_flag = (a.r_tag == b.r_tag) && a.r_value == b.r_value
                           && a.r_sign == b.r_sign;
         OP_GT: begin
            if (a.r_tag != b.r_tag) r.r_flag = a.r_tag > b.r_tag;
            else if (a.r_tag == TAG_REL && a.r_sign != b.r_sign) r.r_flag = a.r_sign;
            else if (a.r_tag != TAG_INV) r.r_flag = x > y;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // queue predictions and compare accepted results
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count  = 0;
         results_due = 0;
      end else begin
         if (req_valid && req_ready) results_queue.push_back(alu_result(req_data));
         if (rsp_valid && rsp_ready) begin
            if (results_queue.size() == 0) begin
               report("unexpected result", rsp_data.r_value, 32'd0);
            end else begin
               want = results_queue.pop_front();
               if (rsp_data.r_value !== want.r_value)
                  report("r_value", rsp_data.r_value, want.r_value);
               if (rsp_data.r_tag !== want.r_tag)
                  report("r_tag", 32'(rsp_data.r_tag), 32'(want.r_tag));
               if (rsp_data.r_sign !== want.r_sign)
                  report("r_sign", 32'(rsp_data.r_sign), 32'(want.r_sign));
               if (rsp_data.r_flag !== want.r_flag)
                  report("r_flag", 32'(rsp_data.r_flag), 32'(want.r_flag));
            end
         end
         results_due = $unsigned(results_queue.size());
      end
   end

endmodule

@@ tb/tagged_stack_relative_alu_core_test.sv @@
// Stimulus and verdict for the tagged stack-relative ALU core.
`timescale 1ns / 100ps
module tagged_stack_relative_alu_core_test;
   import tsra_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned fail_count;
   int unsigned results_due;
   int unsigned cycle_count = 0;

   tsra_req_if req_ch ();
   tsra_rsp_if rsp_ch ();

   tagged_stack_relative_alu_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   tsra_check checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_data    (req_ch.data),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_data    (rsp_ch.data),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // end the run on a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // gap length: mostly short, a few long
   function automatic int unsigned gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // random result stall, with quiet stretches
   initial begin
      int unsigned n;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (1) begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         n = gap_length();
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return $urandom_range(0, 40);
         6: return -$urandom_range(1, 40);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] pick_tag();
      return ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
   endfunction

   task automatic send(logic [3:0] kind, logic [31:0] av, logic [1:0] at, logic as_,
                       logic [31:0] bv, logic [1:0] bt, logic bs);
      req_ch.data <= '{kind, av, at, as_, bv, bt, bs};
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random();
      send(4'($urandom_range(0, 15)), pick_value(), pick_tag(), 1'($urandom), pick_value(),
           pick_tag(), 1'($urandom));
   endtask

   initial begin
      int unsigned n;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every operation and the corner cases
      send(OP_ADD, 32'h7FFF_FFFF, TAG_ABS, 0, 32'd1, TAG_ABS, 0);
      send(OP_ADD, 32'd5, TAG_REL, 1, 32'd3, TAG_REL, 1);
      send(OP_ADD, 32'd5, TAG_REL, 1, 32'd3, TAG_REL, 0);
      send(OP_SUB, 32'd5, TAG_ABS, 0, 32'd3, TAG_REL, 1);
      send(OP_SUB, 32'd5, TAG_REL, 0, 32'd3, TAG_REL, 0);
      send(OP_NEG, 32'h8000_0000, TAG_REL, 1, 0, TAG_INV, 0);
      send(OP_NOT, 32'd0, TAG_ABS, 0, 0, TAG_INV, 0);
      send(OP_NOT, 32'd7, 2'd3, 1, 0, TAG_INV, 0);
      send(OP_MUL, 32'd9, TAG_REL, 1, 32'hFFFF_FFFF, TAG_ABS, 0);
      send(OP_MUL, 32'h8000_0000, TAG_ABS, 0, 32'h7FFF_FFFF, TAG_ABS, 0);
      send(OP_DIV, 32'd9, TAG_ABS, 0, 32'd0, TAG_ABS, 0);
      send(OP_DIV, 32'h8000_0000, TAG_ABS, 0, 32'hFFFF_FFFF, TAG_ABS, 0);
      send(OP_DIV, -32'd7, TAG_ABS, 0, 32'd2, TAG_ABS, 0);
      send(OP_MOD, 32'd9, TAG_REL, 1, 32'd1, TAG_ABS, 0);
      send(OP_MOD, -32'd7, TAG_ABS, 0, 32'd3, TAG_ABS, 0);
      send(OP_MOD, 32'h8000_0000, TAG_ABS, 0, 32'hFFFF_FFFF, TAG_ABS, 0);
      send(OP_SHL, 32'd3, TAG_REL, 0, 32'd0, TAG_ABS, 0);
      send(OP_SHL, 32'd3, TAG_ABS, 0, 32'd31, TAG_ABS, 0);
      send(OP_SHR, 32'h8000_0000, TAG_ABS, 0, 32'd32, TAG_ABS, 0);
      send(OP_SHR, 32'h8000_0000, TAG_ABS, 0, 32'd31, TAG_ABS, 0);
      send(OP_SHL, 32'd3, TAG_ABS, 0, 32'hFFFF_FFF0, TAG_ABS, 0);
      send(OP_EQ, 32'd4, TAG_INV, 1, 32'd9, 2'd3, 0);
      send(OP_GT, 32'd4, TAG_REL, 1, 32'd9, TAG_REL, 0);
      send(OP_GT, -32'd1, TAG_ABS, 0, 32'd1, TAG_ABS, 0);
      send(4'd15, 32'hFFFF_FFFF, TAG_ABS, 1, 32'hFFFF_FFFF, TAG_ABS, 1);

      // random requests with gaps
      repeat (1450) begin
         n = ($urandom_range(0, 3) == 0) ? 0 : gap_length();
         if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge clock);
         end
         send_random();
      end
      req_ch.valid <= 1'b0;

      // drain, then allow the pipeline depth
      while (results_due != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/tsra_pkg.sv
hdl/tsra_if.sv
hdl/tsra_decode.sv
hdl/tsra_div_step.sv
hdl/tagged_stack_relative_alu_core.sv
tb/tsra_check.sv
tb/tagged_stack_relative_alu_core_test.sv
